// ===== rtl/kpvt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the position/velocity tracker.
package kpvt_pkg;

    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 16;
    localparam int DT_W    = 16;
    localparam int REG_W   = 31;
    localparam int MAG_W   = VALUE_W + FRAC_W;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] CFG_INIT_POS = 3'd0;
    localparam logic [IDX_W-1:0] CFG_INIT_VEL = 3'd1;
    localparam logic [IDX_W-1:0] CFG_INIT_COV = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PROC_NS  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MEAS_NS  = 3'd4;

    localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] ONE  = VALUE_W'(1) << FRAC_W;

    localparam logic [REG_W-1:0] RST_INIT_COV = REG_W'(65536);
    localparam logic [REG_W-1:0] RST_PROC_NS  = REG_W'(65);
    localparam logic [REG_W-1:0] RST_MEAS_NS  = REG_W'(65536);

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_PRE_DIV = 5'd10;
    localparam logic [STEP_W-1:0] STEP_LAST    = 5'd17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV0_GO,
        ST_DIV0_WT,
        ST_DIV1_GO,
        ST_DIV1_WT,
        ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_ZERO, OP_ONE, OP_POS, OP_VEL, OP_CPP, OP_CPV, OP_CVP, OP_CVV,
        OP_Q, OP_R, OP_DT, OP_DT2, OP_PP, OP_P00, OP_P01, OP_P10,
        OP_P11, OP_T, OP_S, OP_K0, OP_K1, OP_INN, OP_OMK, OP_MEAS
    } t_opnd;

    // one step: dst = c (+/-) sat((a*b) >> FRAC_W)
    typedef struct packed {
        t_opnd dst;
        t_opnd a;
        t_opnd b;
        t_opnd c;
        logic  sub;
    } t_uop;

    // divider handshake to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, 1'b0};
        case (step)
            5'd0:  u = '{OP_DT2, OP_DT,  OP_DT,  OP_ZERO, 1'b0};
            5'd1:  u = '{OP_PP,  OP_VEL, OP_DT,  OP_POS,  1'b0};
            5'd2:  u = '{OP_T,   OP_CPV, OP_ONE, OP_CVP,  1'b0};
            5'd3:  u = '{OP_P00, OP_T,   OP_DT,  OP_CPP,  1'b0};
            5'd4:  u = '{OP_P00, OP_CVV, OP_DT2, OP_P00,  1'b0};
            5'd5:  u = '{OP_P00, OP_Q,   OP_DT2, OP_P00,  1'b0};
            5'd6:  u = '{OP_P01, OP_CVV, OP_DT,  OP_CPV,  1'b0};
            5'd7:  u = '{OP_P10, OP_CVV, OP_DT,  OP_CVP,  1'b0};
            5'd8:  u = '{OP_P11, OP_Q,   OP_ONE, OP_CVV,  1'b0};
            5'd9:  u = '{OP_INN, OP_PP,  OP_ONE, OP_MEAS, 1'b1};
            5'd10: u = '{OP_S,   OP_R,   OP_ONE, OP_P00,  1'b0};
            5'd11: u = '{OP_POS, OP_K0,  OP_INN, OP_PP,   1'b0};
            5'd12: u = '{OP_VEL, OP_K1,  OP_INN, OP_VEL,  1'b0};
            5'd13: u = '{OP_OMK, OP_K0,  OP_ONE, OP_ONE,  1'b1};
            5'd14: u = '{OP_CPP, OP_OMK, OP_P00, OP_ZERO, 1'b0};
            5'd15: u = '{OP_CPV, OP_OMK, OP_P01, OP_ZERO, 1'b0};
            5'd16: u = '{OP_CVP, OP_K1,  OP_P00, OP_P10,  1'b1};
            5'd17: u = '{OP_CVV, OP_K1,  OP_P01, OP_P11,  1'b1};
            default: u = '{OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, 1'b0};
        endcase
        return u;
    endfunction

    function automatic logic [VALUE_W-1:0] mag(input logic signed [VALUE_W-1:0] a);
        return a[VALUE_W-1] ? VALUE_W'(-a) : VALUE_W'(a);
    endfunction

    // magnitude with sign back to a saturated signed value
    function automatic logic signed [VALUE_W-1:0] sat_mag(input logic [MAG_W-1:0] m,
                                                          input logic neg);
        logic [MAG_W-1:0] lim;
        lim = MAG_W'(VMAX);
        if (neg) begin
            if (m > lim + MAG_W'(1)) return VMIN;
            return VALUE_W'(-m[VALUE_W-1:0]);
        end
        if (m > lim) return VMAX;
        return m[VALUE_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_add(input logic signed [VALUE_W-1:0] c,
                                                          input logic signed [VALUE_W-1:0] x,
                                                          input logic sub);
        logic signed [VALUE_W:0] s;
        s = sub ? ({c[VALUE_W-1], c} - {x[VALUE_W-1], x})
                : ({c[VALUE_W-1], c} + {x[VALUE_W-1], x});
        if (s[VALUE_W] != s[VALUE_W-1]) return s[VALUE_W] ? VMIN : VMAX;
        return s[VALUE_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] pos_reg(input logic [REG_W-1:0] u);
        return (u == '0) ? VALUE_W'(1) : VALUE_W'(u);
    endfunction

endpackage

// ===== rtl/kalman_position_velocity_tracker.sv =====
// Top level: two-state constant-velocity Kalman tracker, Q16.16, shared multiply-add unit.
//
// Input channel (i_valid / o_ready) carries one word: action, measured position and
// time step. Output channel (o_valid / i_ready) returns one word per input word:
// position and velocity estimates and the updated flag.
// Configuration: i_cfg_we with i_cfg_index / i_cfg_data writes one register per cycle
// (0 init position, 1 init velocity, 2 init covariance, 3 q, 4 r); write only when idle.
//
// Sequence: a restart or a zero time step goes from idle straight to the output state.
// An update runs 18 multiply-add steps on one 32x32 multiplier, each a multiply state
// (product registered) and an accumulate state (shift, saturate and add), with two
// serial divisions for the gains after the eleventh step.
// One word is in flight at a time; o_ready is high only while the sequencer is idle.
//
// The result sits in an output register, so a new word is accepted while an old result
// waits; a finished word waits in the sequencer until that register frees up, so a
// stalled receiver holds the block back by at most one word.
// Reset (synchronous, active low) returns registers to their reset values, reloads the
// state from them and empties the output register.
module kalman_position_velocity_tracker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_action,
    input  logic signed [kpvt_pkg::VALUE_W-1:0]  i_measured_position,
    input  logic        [kpvt_pkg::DT_W-1:0]     i_time_step,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [kpvt_pkg::VALUE_W-1:0]  o_position_estimate,
    output logic signed [kpvt_pkg::VALUE_W-1:0]  o_velocity_estimate,
    output logic                                 o_updated,
    input  logic                                 i_cfg_we,
    input  logic        [kpvt_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic        [kpvt_pkg::VALUE_W-1:0]  i_cfg_data
);
    localparam int VW = kpvt_pkg::VALUE_W;

    kpvt_pkg::t_state r_state, n_state;

    // configuration
    logic signed [VW-1:0]             r_init_pos, r_init_vel;
    logic [kpvt_pkg::REG_W-1:0]       r_init_cov, r_proc_ns, r_meas_ns;

    // filter state and scratch
    logic signed [VW-1:0] r_pos, r_vel, r_cpp, r_cpv, r_cvp, r_cvv;
    logic signed [VW-1:0] r_dt2, r_pp, r_p00, r_p01, r_p10, r_p11, r_t, r_s;
    logic signed [VW-1:0] r_k0, r_k1, r_inn, r_omk, r_meas;
    logic [kpvt_pkg::DT_W-1:0] r_dt;
    logic                      r_upd;
    logic [kpvt_pkg::STEP_W-1:0] r_step;

    // shared unit
    logic [kpvt_pkg::PROD_W-1:0] r_prod;
    logic                        r_neg;
    logic signed [VW-1:0]        w_a, w_b, w_c, w_res;
    kpvt_pkg::t_uop              w_uop;

    // divider
    logic                        w_div_start;
    logic [kpvt_pkg::REG_W-1:0]  w_div_den;
    logic signed [VW-1:0]        w_div_num, w_quot;
    kpvt_pkg::t_div_stat         w_div_stat;

    // output register
    logic                 r_o_valid, r_o_upd;
    logic signed [VW-1:0] r_o_pos, r_o_vel;
    logic                 w_accept, w_out_free, w_out_load;

    function automatic logic signed [VW-1:0] pick(input kpvt_pkg::t_opnd o,
            input logic signed [VW-1:0] pos, vel, cpp, cpv, cvp, cvv, dt2, pp, p00,
            input logic signed [VW-1:0] p01, p10, p11, t, s, k0, k1, inn, omk, meas,
            input logic [kpvt_pkg::DT_W-1:0] dt,
            input logic [kpvt_pkg::REG_W-1:0] qn, rn);
        case (o)
            kpvt_pkg::OP_ZERO: return '0;
            kpvt_pkg::OP_ONE:  return kpvt_pkg::ONE;
            kpvt_pkg::OP_POS:  return pos;
            kpvt_pkg::OP_VEL:  return vel;
            kpvt_pkg::OP_CPP:  return cpp;
            kpvt_pkg::OP_CPV:  return cpv;
            kpvt_pkg::OP_CVP:  return cvp;
            kpvt_pkg::OP_CVV:  return cvv;
            kpvt_pkg::OP_Q:    return kpvt_pkg::pos_reg(qn);
            kpvt_pkg::OP_R:    return kpvt_pkg::pos_reg(rn);
            kpvt_pkg::OP_DT:   return VW'(dt);
            kpvt_pkg::OP_DT2:  return dt2;
            kpvt_pkg::OP_PP:   return pp;
            kpvt_pkg::OP_P00:  return p00;
            kpvt_pkg::OP_P01:  return p01;
            kpvt_pkg::OP_P10:  return p10;
            kpvt_pkg::OP_P11:  return p11;
            kpvt_pkg::OP_T:    return t;
            kpvt_pkg::OP_S:    return s;
            kpvt_pkg::OP_K0:   return k0;
            kpvt_pkg::OP_K1:   return k1;
            kpvt_pkg::OP_INN:  return inn;
            kpvt_pkg::OP_OMK:  return omk;
            kpvt_pkg::OP_MEAS: return meas;
            default:           return '0;
        endcase
    endfunction

    always_comb begin
        w_uop = kpvt_pkg::ucode(r_step);
        w_a = pick(w_uop.a, r_pos, r_vel, r_cpp, r_cpv, r_cvp, r_cvv, r_dt2, r_pp, r_p00,
                   r_p01, r_p10, r_p11, r_t, r_s, r_k0, r_k1, r_inn, r_omk, r_meas,
                   r_dt, r_proc_ns, r_meas_ns);
        w_b = pick(w_uop.b, r_pos, r_vel, r_cpp, r_cpv, r_cvp, r_cvv, r_dt2, r_pp, r_p00,
                   r_p01, r_p10, r_p11, r_t, r_s, r_k0, r_k1, r_inn, r_omk, r_meas,
                   r_dt, r_proc_ns, r_meas_ns);
        w_c = pick(w_uop.c, r_pos, r_vel, r_cpp, r_cpv, r_cvp, r_cvv, r_dt2, r_pp, r_p00,
                   r_p01, r_p10, r_p11, r_t, r_s, r_k0, r_k1, r_inn, r_omk, r_meas,
                   r_dt, r_proc_ns, r_meas_ns);
        // shift the registered product down and saturate, then add to c
        w_res = kpvt_pkg::sat_add(w_c,
                    kpvt_pkg::sat_mag(r_prod[kpvt_pkg::PROD_W-1:kpvt_pkg::FRAC_W], r_neg),
                    w_uop.sub);
    end

    // gain divisor: innovation covariance, at least one LSB
    assign w_div_den = (r_s < 1) ? kpvt_pkg::REG_W'(1) : r_s[kpvt_pkg::REG_W-1:0];
    assign w_div_num = (r_state == kpvt_pkg::ST_DIV0_GO) ? r_p00 : r_p10;

    kpvt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            kpvt_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action || i_time_step == '0) n_state = kpvt_pkg::ST_OUT;
                    else                               n_state = kpvt_pkg::ST_MUL;
                end
            end
            kpvt_pkg::ST_MUL: n_state = kpvt_pkg::ST_ACC;
            kpvt_pkg::ST_ACC: begin
                if (r_step == kpvt_pkg::STEP_PRE_DIV)   n_state = kpvt_pkg::ST_DIV0_GO;
                else if (r_step == kpvt_pkg::STEP_LAST) n_state = kpvt_pkg::ST_OUT;
                else                                    n_state = kpvt_pkg::ST_MUL;
            end
            kpvt_pkg::ST_DIV0_GO: begin
                w_div_start = 1'b1;
                n_state     = kpvt_pkg::ST_DIV0_WT;
            end
            kpvt_pkg::ST_DIV0_WT: if (w_div_stat.done) n_state = kpvt_pkg::ST_DIV1_GO;
            kpvt_pkg::ST_DIV1_GO: begin
                w_div_start = 1'b1;
                n_state     = kpvt_pkg::ST_DIV1_WT;
            end
            kpvt_pkg::ST_DIV1_WT: if (w_div_stat.done) n_state = kpvt_pkg::ST_MUL;
            kpvt_pkg::ST_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = kpvt_pkg::ST_IDLE;
                end
            end
            default: n_state = kpvt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= kpvt_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // configuration, filter state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_pos <= '0;
            r_init_vel <= '0;
            r_init_cov <= kpvt_pkg::RST_INIT_COV;
            r_proc_ns  <= kpvt_pkg::RST_PROC_NS;
            r_meas_ns  <= kpvt_pkg::RST_MEAS_NS;
            r_pos      <= '0;
            r_vel      <= '0;
            r_cpp      <= kpvt_pkg::pos_reg(kpvt_pkg::RST_INIT_COV);
            r_cpv      <= '0;
            r_cvp      <= '0;
            r_cvv      <= kpvt_pkg::pos_reg(kpvt_pkg::RST_INIT_COV);
            r_step     <= '0;
            r_upd      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kpvt_pkg::CFG_INIT_POS: r_init_pos <= i_cfg_data;
                    kpvt_pkg::CFG_INIT_VEL: r_init_vel <= i_cfg_data;
                    kpvt_pkg::CFG_INIT_COV: r_init_cov <= i_cfg_data[kpvt_pkg::REG_W-1:0];
                    kpvt_pkg::CFG_PROC_NS:  r_proc_ns  <= i_cfg_data[kpvt_pkg::REG_W-1:0];
                    kpvt_pkg::CFG_MEAS_NS:  r_meas_ns  <= i_cfg_data[kpvt_pkg::REG_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_meas <= i_measured_position;
                r_dt   <= i_time_step;
                r_step <= '0;
                r_upd  <= i_action || (i_time_step != '0);
                if (i_action) begin
                    r_pos <= r_init_pos;
                    r_vel <= r_init_vel;
                    r_cpp <= kpvt_pkg::pos_reg(r_init_cov);
                    r_cpv <= '0;
                    r_cvp <= '0;
                    r_cvv <= kpvt_pkg::pos_reg(r_init_cov);
                end
            end
            if (r_state == kpvt_pkg::ST_ACC) begin
                r_step <= r_step + kpvt_pkg::STEP_W'(1);
                case (w_uop.dst)
                    kpvt_pkg::OP_POS: r_pos <= w_res;
                    kpvt_pkg::OP_VEL: r_vel <= w_res;
                    kpvt_pkg::OP_CPP: r_cpp <= w_res;
                    kpvt_pkg::OP_CPV: r_cpv <= w_res;
                    kpvt_pkg::OP_CVP: r_cvp <= w_res;
                    kpvt_pkg::OP_CVV: r_cvv <= w_res;
                    kpvt_pkg::OP_DT2: r_dt2 <= w_res;
                    kpvt_pkg::OP_PP:  r_pp  <= w_res;
                    kpvt_pkg::OP_P00: r_p00 <= w_res;
                    kpvt_pkg::OP_P01: r_p01 <= w_res;
                    kpvt_pkg::OP_P10: r_p10 <= w_res;
                    kpvt_pkg::OP_P11: r_p11 <= w_res;
                    kpvt_pkg::OP_T:   r_t   <= w_res;
                    kpvt_pkg::OP_S:   r_s   <= w_res;
                    kpvt_pkg::OP_INN: r_inn <= w_res;
                    kpvt_pkg::OP_OMK: r_omk <= w_res;
                    default: ;
                endcase
            end
            if (r_state == kpvt_pkg::ST_DIV0_WT && w_div_stat.done) r_k0 <= w_quot;
            if (r_state == kpvt_pkg::ST_DIV1_WT && w_div_stat.done) r_k1 <= w_quot;
        end
    end

    // product of magnitudes, sign kept apart
    always_ff @(posedge i_clk) begin
        if (r_state == kpvt_pkg::ST_MUL) begin
            r_prod <= kpvt_pkg::PROD_W'(kpvt_pkg::mag(w_a)) *
                      kpvt_pkg::PROD_W'(kpvt_pkg::mag(w_b));
            r_neg  <= w_a[VW-1] ^ w_b[VW-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (w_out_load)              r_o_valid <= 1'b1;
            else if (r_o_valid && i_ready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_pos <= r_pos;
            r_o_vel <= r_vel;
            r_o_upd <= r_upd;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_position_estimate = r_o_pos;
    assign o_velocity_estimate = r_o_vel;
    assign o_updated           = r_o_upd;

endmodule

// ===== rtl/kpvt_div.sv =====
// Serial restoring divider: sat((|n| << FRAC_W) / d) with the sign of n, one quotient bit a cycle.
module kpvt_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [kpvt_pkg::VALUE_W-1:0]   i_num,
    input  logic        [kpvt_pkg::REG_W-1:0]     i_den,
    output kpvt_pkg::t_div_stat                   o_stat,
    output logic signed [kpvt_pkg::VALUE_W-1:0]   o_quot
);
    localparam int CNT_W = $clog2(kpvt_pkg::MAG_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(kpvt_pkg::MAG_W - 1);

    logic [kpvt_pkg::MAG_W-1:0] r_num;
    logic [kpvt_pkg::MAG_W-1:0] r_q;
    logic [kpvt_pkg::REG_W-1:0] r_den;
    logic [kpvt_pkg::REG_W-1:0] r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_neg;
    logic                       r_busy;
    logic                       r_done;

    logic [kpvt_pkg::REG_W:0]   w_rem2;
    logic                       w_ge;
    logic [kpvt_pkg::REG_W:0]   w_diff;
    logic [kpvt_pkg::REG_W-1:0] n_rem;

    always_comb begin
        w_rem2 = {r_rem, r_num[kpvt_pkg::MAG_W-1]};
        w_ge   = (w_rem2 >= {1'b0, r_den});
        w_diff = w_rem2 - {1'b0, r_den};
        n_rem  = w_ge ? w_diff[kpvt_pkg::REG_W-1:0] : w_rem2[kpvt_pkg::REG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= {kpvt_pkg::mag(i_num), {kpvt_pkg::FRAC_W{1'b0}}};
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
                r_neg  <= i_num[kpvt_pkg::VALUE_W-1];
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[kpvt_pkg::MAG_W-2:0], w_ge};
                r_num <= {r_num[kpvt_pkg::MAG_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = kpvt_pkg::sat_mag(r_q, r_neg);

endmodule

// ===== rtl/kpvt_checker.sv =====
// Port-level checks for the tracker, bound to the top level.
module kpvt_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [kpvt_pkg::VALUE_W-1:0]  o_position_estimate,
    input logic signed [kpvt_pkg::VALUE_W-1:0]  o_velocity_estimate,
    input logic                                 o_updated
);
    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position_estimate)
            && $stable(o_velocity_estimate) && $stable(o_updated))
        else $error("result word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready after accepting a word");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind kalman_position_velocity_tracker kpvt_checker u_kpvt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_ready             (o_ready),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_position_estimate (o_position_estimate),
    .o_velocity_estimate (o_velocity_estimate),
    .o_updated           (o_updated)
);

// ===== tb/tb_kalman_position_velocity_tracker.sv =====
// Testbench for the position/velocity Kalman tracker: queued driver, checking monitor, own predictor.
`timescale 1ns / 1ps

module tb_kalman_position_velocity_tracker;

    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint S32_MIN  = -64'sd2147483648;
    localparam bit  ACT_UPDATE  = 1'b0;
    localparam bit  ACT_RESTART = 1'b1;

    typedef struct {
        logic                                action;
        logic signed [kpvt_pkg::VALUE_W-1:0] meas;
        logic        [kpvt_pkg::DT_W-1:0]    dt;
    } t_word;

    typedef struct {
        logic signed [kpvt_pkg::VALUE_W-1:0] pos;
        logic signed [kpvt_pkg::VALUE_W-1:0] vel;
        logic                                upd;
    } t_est;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, i_action;
    logic signed [kpvt_pkg::VALUE_W-1:0] i_measured_position;
    logic [kpvt_pkg::DT_W-1:0] i_time_step;
    logic o_valid, i_ready;
    logic signed [kpvt_pkg::VALUE_W-1:0] o_position_estimate, o_velocity_estimate;
    logic o_updated;
    logic i_cfg_we;
    logic [kpvt_pkg::IDX_W-1:0] i_cfg_index;
    logic [kpvt_pkg::VALUE_W-1:0] i_cfg_data;

    kalman_position_velocity_tracker u_top (.*);

    // words waiting for the driver, and estimates waiting for the monitor
    t_word  word_q[$];
    t_est   est_q[$];
    bit     quiet;          // no idling on either side in the closing phase
    int     errors;
    longint cycles;

    // predictor copy of registers and filter state
    logic [31:0] m_ipos, m_ivel;
    logic [30:0] m_icov, m_q, m_r;
    longint st_pos, st_vel, st_pp, st_pv, st_vp, st_vv;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp32(input longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic longint from_mag(input longint unsigned m, input bit neg);
        if (neg) begin
            if (m > 64'd2147483648) return S32_MIN;
            return -longint'(m);
        end
        if (m > 64'd2147483647) return S32_MAX;
        return longint'(m);
    endfunction

    function automatic longint unsigned absval(input longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    // (a*b) >> sh, magnitude truncated, then saturated
    function automatic longint mul_shift(input longint a, input longint b, input int sh);
        return from_mag((absval(a) * absval(b)) >> sh, (a < 0) != (b < 0));
    endfunction

    // gain quotient (n << FRAC_W) / d, d >= 1
    function automatic longint gain_div(input longint n, input longint d);
        return from_mag((absval(n) << kpvt_pkg::FRAC_W) / longint'(d), n < 0);
    endfunction

    function automatic longint noise_val(input logic [30:0] u);
        return (u == 31'd0) ? 64'sd1 : longint'({33'd0, u});
    endfunction

    function automatic void reload_state();
        st_pos = longint'(signed'(m_ipos));
        st_vel = longint'(signed'(m_ivel));
        st_pp  = noise_val(m_icov);
        st_vv  = st_pp;
        st_pv  = 0;
        st_vp  = 0;
    endfunction

    function automatic t_est track_word(input t_word w);
        t_est   e;
        longint dt, dt2, q, r, pp, pv, p00, p01, p10, p11, s, k0, k1, inn, omk;
        e.upd = 1'b0;
        dt = longint'({48'd0, w.dt});
        if (w.action == ACT_RESTART) begin
            reload_state();
            e.upd = 1'b1;
        end else if (dt != 0) begin
            q   = noise_val(m_q);
            r   = noise_val(m_r);
            dt2 = (dt * dt) >> kpvt_pkg::DT_W;
            pp  = clamp32(st_pos + mul_shift(st_vel, dt, kpvt_pkg::DT_W));
            pv  = st_vel;
            p00 = clamp32(st_pp + mul_shift(clamp32(st_vp + st_pv), dt, kpvt_pkg::DT_W));
            p00 = clamp32(p00 + mul_shift(st_vv, dt2, kpvt_pkg::DT_W));
            p00 = clamp32(p00 + mul_shift(q, dt2, kpvt_pkg::DT_W));
            p01 = clamp32(st_pv + mul_shift(st_vv, dt, kpvt_pkg::DT_W));
            p10 = clamp32(st_vp + mul_shift(st_vv, dt, kpvt_pkg::DT_W));
            p11 = clamp32(st_vv + q);
            inn = clamp32(longint'(w.meas) - pp);
            s   = clamp32(p00 + r);
            if (s < 1) s = 1;
            k0  = gain_div(p00, s);
            k1  = gain_div(p10, s);
            st_pos = clamp32(pp + mul_shift(k0, inn, kpvt_pkg::FRAC_W));
            st_vel = clamp32(pv + mul_shift(k1, inn, kpvt_pkg::FRAC_W));
            omk   = clamp32(64'sd65536 - k0);
            st_pp = mul_shift(omk, p00, kpvt_pkg::FRAC_W);
            st_pv = mul_shift(omk, p01, kpvt_pkg::FRAC_W);
            st_vp = clamp32(p10 - mul_shift(k1, p00, kpvt_pkg::FRAC_W));
            st_vv = clamp32(p11 - mul_shift(k1, p01, kpvt_pkg::FRAC_W));
            e.upd = 1'b1;
        end
        e.pos = st_pos[31:0];
        e.vel = st_vel[31:0];
        return e;
    endfunction

    // driver: one word at a time from word_q, with random idle bursts
    int  drv_gap;
    initial begin
        i_valid = 1'b0; i_action = 1'b0; i_measured_position = '0; i_time_step = '0;
        drv_gap = 0;
    end
    always @(posedge i_clk) begin
        t_word w;
        logic  busy;
        if (i_rst_n) begin
            busy = i_valid;
            if (i_valid && o_ready) begin
                w.action = i_action; w.meas = i_measured_position; w.dt = i_time_step;
                est_q.push_back(track_word(w));
                busy = 1'b0;
            end
            if (!busy) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    drv_gap <= $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    w = word_q.pop_front();
                    i_valid <= 1'b1;
                    i_action <= w.action;
                    i_measured_position <= w.meas;
                    i_time_step <= w.dt;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stall bursts on i_ready, check each word against the oldest estimate
    int mon_gap;
    initial begin
        i_ready = 1'b0;
        mon_gap = 0;
        errors = 0;
    end
    always @(posedge i_clk) begin
        t_est e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (est_q.size() == 0) begin
                    $display("%0t: unexpected word pos=%0d vel=%0d upd=%0b", $time,
                             o_position_estimate, o_velocity_estimate, o_updated);
                    errors++;
                end else begin
                    e = est_q.pop_front();
                    if (o_position_estimate !== e.pos) begin
                        $display("%0t: position expected %0d actual %0d", $time,
                                 e.pos, o_position_estimate);
                        errors++;
                    end
                    if (o_velocity_estimate !== e.vel) begin
                        $display("%0t: velocity expected %0d actual %0d", $time,
                                 e.vel, o_velocity_estimate);
                        errors++;
                    end
                    if (o_updated !== e.upd) begin
                        $display("%0t: updated expected %0b actual %0b", $time,
                                 e.upd, o_updated);
                        errors++;
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                mon_gap <= $urandom_range(0, 7);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // cycle watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // write enable is left high; the caller drops it after the last write
    task automatic cfg_write(input logic [kpvt_pkg::IDX_W-1:0] idx, input logic [31:0] d);
        case (idx)
            kpvt_pkg::CFG_INIT_POS: m_ipos = d;
            kpvt_pkg::CFG_INIT_VEL: m_ivel = d;
            kpvt_pkg::CFG_INIT_COV: m_icov = d[30:0];
            kpvt_pkg::CFG_PROC_NS:  m_q    = d[30:0];
            kpvt_pkg::CFG_MEAS_NS:  m_r    = d[30:0];
            default: ;
        endcase
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    task automatic push_word(input logic act, input logic [31:0] meas, input logic [15:0] dt);
        t_word w;
        w.action = act; w.meas = meas; w.dt = dt;
        word_q.push_back(w);
    endtask

    // mostly plausible tracking words around a drifting target, some noise
    task automatic push_random(input int n);
        logic [31:0] target;
        logic [15:0] dt;
        target = $urandom_range(0, 65535) << 4;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0:       push_word(ACT_RESTART, $urandom, 16'($urandom));
                1:       push_word(ACT_UPDATE, $urandom, 16'd0);
                2, 3:    push_word(ACT_UPDATE, $urandom, 16'($urandom));
                default: begin
                    dt = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 8192));
                    target = target + 32'($urandom_range(0, 131072)) - 32'd65536;
                    push_word(ACT_UPDATE, target + 32'($urandom_range(0, 8191)) - 32'd4096, dt);
                end
            endcase
        end
    endtask

    // wait until nothing is queued, driven or outstanding for several cycles in a row
    task automatic drain();
        int calm;
        calm = 0;
        while (calm < 4) begin
            @(posedge i_clk);
            if (word_q.size() != 0 || i_valid || est_q.size() != 0 || o_valid) calm = 0;
            else calm++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        quiet = 1'b0;
        m_ipos = '0; m_ivel = '0;
        m_icov = kpvt_pkg::RST_INIT_COV; m_q = kpvt_pkg::RST_PROC_NS;
        m_r = kpvt_pkg::RST_MEAS_NS;
        reload_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset values, zero step, step extremes, measurement extremes
        push_word(ACT_UPDATE, 32'h0001_0000, 16'd0);
        push_word(ACT_UPDATE, 32'h0001_0000, 16'd1);
        push_word(ACT_UPDATE, 32'h7FFF_FFFF, 16'hFFFF);
        push_word(ACT_UPDATE, 32'h8000_0000, 16'hFFFF);
        push_word(ACT_UPDATE, 32'h8000_0000, 16'h8000);
        push_word(ACT_UPDATE, 32'h7FFF_FFFF, 16'd1);
        push_word(ACT_UPDATE, 32'h0000_0000, 16'd0);
        push_word(ACT_RESTART, 32'hFFFF_FFFF, 16'hFFFF);
        push_word(ACT_UPDATE, 32'hFFFF_FFFF, 16'h0100);
        push_word(ACT_UPDATE, 32'h0000_0000, 16'hFFFF);
        drain();

        // extreme registers: saturated start, zero noises clamp to one LSB
        cfg_write(kpvt_pkg::CFG_INIT_POS, 32'h7FFF_FFFF);
        cfg_write(kpvt_pkg::CFG_INIT_VEL, 32'h7FFF_FFFF);
        cfg_write(kpvt_pkg::CFG_INIT_COV, 32'h0000_0000);
        cfg_write(kpvt_pkg::CFG_PROC_NS, 32'h0000_0000);
        cfg_write(kpvt_pkg::CFG_MEAS_NS, 32'h0000_0000);
        i_cfg_we <= 1'b0;
        push_word(ACT_RESTART, 32'd0, 16'd0);
        push_word(ACT_UPDATE, 32'h7FFF_FFFF, 16'hFFFF);
        push_word(ACT_UPDATE, 32'h8000_0000, 16'hFFFF);
        push_word(ACT_UPDATE, 32'h8000_0000, 16'd1);
        push_word(ACT_UPDATE, 32'h0000_0000, 16'd0);
        drain();

        // top bit set on the 31-bit registers, maximum noises, negative start
        cfg_write(kpvt_pkg::CFG_INIT_POS, 32'h8000_0000);
        cfg_write(kpvt_pkg::CFG_INIT_VEL, 32'h8000_0000);
        cfg_write(kpvt_pkg::CFG_INIT_COV, 32'hFFFF_FFFF);
        cfg_write(kpvt_pkg::CFG_PROC_NS, 32'hFFFF_FFFF);
        cfg_write(kpvt_pkg::CFG_MEAS_NS, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        push_word(ACT_RESTART, 32'd0, 16'd0);
        push_word(ACT_UPDATE, 32'h7FFF_FFFF, 16'hFFFF);
        push_word(ACT_UPDATE, 32'h8000_0000, 16'hFFFF);
        push_word(ACT_UPDATE, 32'h1234_5678, 16'h00FF);
        drain();

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < 7; ph++) begin
            cfg_write(kpvt_pkg::CFG_INIT_POS,
                      $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 255) << 16));
            cfg_write(kpvt_pkg::CFG_INIT_VEL,
                      $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 15) << 16));
            cfg_write(kpvt_pkg::CFG_INIT_COV,
                      $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 1 << 20));
            cfg_write(kpvt_pkg::CFG_PROC_NS,
                      $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 4096));
            cfg_write(kpvt_pkg::CFG_MEAS_NS,
                      $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1 << 20));
            i_cfg_we <= 1'b0;
            if (ph == 6) quiet = 1'b1;
            push_word(ACT_RESTART, $urandom, 16'($urandom));
            push_random(195);
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
